@@ hw/rtl/rab_pkg.sv @@
package rab_pkg;

	localparam int ADDR_BITS_DEF = 24;
	localparam int MAX_DIM_DEF   = 4096;
	localparam int DIM_BITS      = 13;
	localparam int PIX_BITS      = 32;
	localparam int OFS_BITS      = 24;
	localparam int RGB_BITS      = 24;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int STRIDE_BITS   = 16;
	localparam logic [7:0] ALPHA_MAX = 8'd255;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MODE        = 3'd0,
		CFG_FILL_COLOR  = 3'd1,
		CFG_DEST_STRIDE = 3'd2,
		CFG_DEST_START  = 3'd3,
		CFG_SRC_STRIDE  = 3'd4,
		CFG_SRC_START   = 3'd5,
		CFG_RECT_WIDTH  = 3'd6,
		CFG_RECT_HEIGHT = 3'd7
	} cfg_idx_t;

	// (a*s + (255-a)*d) / 255, truncated; divide by 255 via add-and-shift
	function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] s,
			input logic [7:0] d);
		logic [15:0] num;
		logic [16:0] adj;
		num = 16'(a * s) + 16'((ALPHA_MAX - a) * d);
		adj = 17'(num) + 17'(num[15:8]) + 17'd1;
		return adj[15:8];
	endfunction

endpackage

@@ hw/rtl/rab_if.sv @@
interface rab_in_if;
	import rab_pkg::*;
	logic                valid;
	logic                ready;
	logic [PIX_BITS-1:0] dest_pixel;
	logic [PIX_BITS-1:0] src_pixel;
	modport source (output valid, output dest_pixel, output src_pixel, input ready);
	modport sink (input valid, input dest_pixel, input src_pixel, output ready);
endinterface

interface rab_out_if;
	import rab_pkg::*;
	logic                valid;
	logic                ready;
	logic [RGB_BITS-1:0] blended_pixel;
	logic [OFS_BITS-1:0] dest_offset;
	logic [OFS_BITS-1:0] src_offset;
	logic                last;
	modport source (output valid, output blended_pixel, output dest_offset,
		output src_offset, output last, input ready);
	modport sink (input valid, input blended_pixel, input dest_offset,
		input src_offset, input last, output ready);
endinterface

@@ hw/rtl/rect_alpha_blend_blitter.sv @@
// Source-over alpha blitter for a rectangle walked in row-major order. Each accepted request
// carries the destination pixel (and the source pixel in image mode) and yields one blended
// RGB888 result with its destination and source byte offsets and a last flag on the final pixel;
// an empty rectangle yields nothing. Throughput is one request per clock while the output accepts:
// offsets and the row and column counters are settled in the accept cycle, offsets into stage 1,
// and the three 8x8 channel blends are registered in stage 2; output stalls back-pressure the input.
// Configure only while no request is in flight; a walk resumes from the current counters.
module rect_alpha_blend_blitter #(
	parameter int ADDR_BITS = rab_pkg::ADDR_BITS_DEF,
	parameter int MAX_DIM   = rab_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rab_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rab_pkg::CFG_DATA_BITS-1:0] cfg_data,
	rab_in_if.sink                           in_ch,
	rab_out_if.source                        out_ch
);
	import rab_pkg::*;

	logic                   mode_q;
	logic [PIX_BITS-1:0]    fill_color_q;
	logic [STRIDE_BITS-1:0] dest_stride_q;
	logic [OFS_BITS-1:0]    dest_start_q;
	logic [STRIDE_BITS-1:0] src_stride_q;
	logic [OFS_BITS-1:0]    src_start_q;
	logic [DIM_BITS-1:0]    rect_width_q;
	logic [DIM_BITS-1:0]    rect_height_q;

	logic [DIM_BITS-1:0]  col_q;
	logic [DIM_BITS-1:0]  row_q;
	logic [ADDR_BITS-1:0] dbase_q;
	logic [ADDR_BITS-1:0] sbase_q;

	logic                v_s1;
	logic [PIX_BITS-1:0] dst_s1;
	logic [PIX_BITS-1:0] src_s1;
	logic [OFS_BITS-1:0] doff_s1;
	logic [OFS_BITS-1:0] soff_s1;
	logic                last_s1;

	logic                v_s2;
	logic [RGB_BITS-1:0] rgb_s2;
	logic [OFS_BITS-1:0] doff_s2;
	logic [OFS_BITS-1:0] soff_s2;
	logic                last_s2;

	logic [DIM_BITS:0]    w_c;
	logic [DIM_BITS:0]    h_c;
	logic                 empty;
	logic                 acc;
	logic                 go;
	logic                 adv;
	logic                 row_end;
	logic                 rect_end;
	logic [ADDR_BITS-1:0] col_bytes;
	logic [ADDR_BITS-1:0] doff_a;
	logic [ADDR_BITS-1:0] soff_a;
	logic [31:0]          doff_w;
	logic [31:0]          soff_w;
	logic [RGB_BITS-1:0]  rgb_c;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= 1'b0;
			fill_color_q  <= '0;
			dest_stride_q <= '0;
			dest_start_q  <= '0;
			src_stride_q  <= '0;
			src_start_q   <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MODE:        mode_q        <= cfg_data[0];
				CFG_FILL_COLOR:  fill_color_q  <= cfg_data[PIX_BITS-1:0];
				CFG_DEST_STRIDE: dest_stride_q <= cfg_data[STRIDE_BITS-1:0];
				CFG_DEST_START:  dest_start_q  <= cfg_data[OFS_BITS-1:0];
				CFG_SRC_STRIDE:  src_stride_q  <= cfg_data[STRIDE_BITS-1:0];
				CFG_SRC_START:   src_start_q   <= cfg_data[OFS_BITS-1:0];
				CFG_RECT_WIDTH:  rect_width_q  <= cfg_data[DIM_BITS-1:0];
				CFG_RECT_HEIGHT: rect_height_q <= cfg_data[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv         = !v_s2 || out_ch.ready;
	assign in_ch.ready = !v_s1 || adv;
	assign acc         = in_ch.valid && in_ch.ready;

	// rectangle walk
	assign w_c = ({1'b0, rect_width_q} > (DIM_BITS+1)'(MAX_DIM)) ? (DIM_BITS+1)'(MAX_DIM)
		: {1'b0, rect_width_q};
	assign h_c = ({1'b0, rect_height_q} > (DIM_BITS+1)'(MAX_DIM)) ? (DIM_BITS+1)'(MAX_DIM)
		: {1'b0, rect_height_q};
	assign empty    = (w_c == '0) || (h_c == '0);
	assign go       = acc && !empty;
	assign row_end  = ({1'b0, col_q} + (DIM_BITS+1)'(1)) >= w_c;
	assign rect_end = row_end && (({1'b0, row_q} + (DIM_BITS+1)'(1)) >= h_c);

	assign col_bytes = ADDR_BITS'({col_q, 2'b00});
	assign doff_a    = ADDR_BITS'(dest_start_q) + dbase_q + col_bytes;
	assign soff_a    = ADDR_BITS'(src_start_q) + sbase_q + col_bytes;
	assign doff_w    = 32'(doff_a);
	assign soff_w    = 32'(soff_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			dbase_q <= '0;
			sbase_q <= '0;
		end else if (go) begin
			if (rect_end) begin
				col_q   <= '0;
				row_q   <= '0;
				dbase_q <= '0;
				sbase_q <= '0;
			end else if (row_end) begin
				col_q   <= '0;
				row_q   <= row_q + DIM_BITS'(1);
				dbase_q <= dbase_q + ADDR_BITS'(dest_stride_q);
				sbase_q <= sbase_q + ADDR_BITS'(src_stride_q);
			end else begin
				col_q <= col_q + DIM_BITS'(1);
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dst_s1  <= in_ch.dest_pixel;
			src_s1  <= mode_q ? in_ch.src_pixel : fill_color_q;
			doff_s1 <= doff_w[OFS_BITS-1:0];
			soff_s1 <= mode_q ? soff_w[OFS_BITS-1:0] : '0;
			last_s1 <= rect_end;
		end
	end

	// blend
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rgb_c[i*8 +: 8] = blend_chan(src_s1[31:24], src_s1[i*8 +: 8], dst_s1[i*8 +: 8]);
		end
	end

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			rgb_s2  <= rgb_c;
			doff_s2 <= doff_s1;
			soff_s2 <= soff_s1;
			last_s2 <= last_s1;
		end
	end

	assign out_ch.valid         = v_s2;
	assign out_ch.blended_pixel = rgb_s2;
	assign out_ch.dest_offset   = doff_s2;
	assign out_ch.src_offset    = soff_s2;
	assign out_ch.last          = last_s2;

	a_rect_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		go && rect_end |=> (col_q == '0) && (row_q == '0))
		else $error("counters not cleared after final pixel");

	a_row0_base0: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q == '0) |-> (dbase_q == '0) && (sbase_q == '0))
		else $error("row base nonzero on first row");

	a_go_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> v_s1)
		else $error("accepted request lost before stage 1");

	a_empty_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		acc && empty && !v_s1 |=> !v_s1)
		else $error("empty rectangle produced a result");

endmodule
